@@ src/cwr_pkg.sv @@
// Shared types, constants and the kana width table for the CSV kana rewriter.
package cwr_pkg;

    localparam int MAX_FIELDS_DEF      = 32;
    localparam int MAX_FIELD_BYTES_DEF = 256;
    localparam int KANA_FIELD_DEF      = 3;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic MODE_CSV = 1'b0;
    localparam logic MODE_LF  = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] KANA_LO  = 8'hA1;
    localparam logic [7:0] KANA_HI  = 8'hDF;
    localparam logic [7:0] ASCII_HI = 8'h7F;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_ONE   = 2'd1;
    localparam logic [1:0] KIND_MATCH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       err;
        logic       last;
    } res_t;

    // One or two result words caused by one input word.
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } cmd_t;

    // Lookup result: hit, first byte (0 = none), second byte.
    typedef struct packed {
        logic       hit;
        logic [7:0] first;
        logic [7:0] second;
    } kana_t;

    function automatic kana_t kana_lookup(input logic [15:0] pair);
        kana_t k;
        k.hit = 1'b1;
        k.first = 8'h00;
        k.second = 8'h00;
        case (pair)
            16'h8141: k.second = 8'hA4;  16'h8142: k.second = 8'hA1;
            16'h8145: k.second = 8'hA5;  16'h814A: k.second = 8'hDE;
            16'h814B: k.second = 8'hDF;  16'h815B: k.second = 8'hB0;
            16'h8175: k.second = 8'hA2;  16'h8176: k.second = 8'hA3;
            16'h8340: k.second = 8'hA7;  16'h8341: k.second = 8'hB1;
            16'h8342: k.second = 8'hA8;  16'h8343: k.second = 8'hB2;
            16'h8344: k.second = 8'hA9;  16'h8345: k.second = 8'hB3;
            16'h8346: k.second = 8'hAA;  16'h8347: k.second = 8'hB4;
            16'h8348: k.second = 8'hAB;  16'h8349: k.second = 8'hB5;
            16'h834A: k.second = 8'hB6;
            16'h834B: begin k.first = 8'hB6; k.second = 8'hDE; end
            16'h834C: k.second = 8'hB7;
            16'h834D: begin k.first = 8'hB7; k.second = 8'hDE; end
            16'h834E: k.second = 8'hB8;
            16'h834F: begin k.first = 8'hB8; k.second = 8'hDE; end
            16'h8350: k.second = 8'hB9;
            16'h8351: begin k.first = 8'hB9; k.second = 8'hDE; end
            16'h8352: k.second = 8'hBA;
            16'h8353: begin k.first = 8'hBA; k.second = 8'hDE; end
            16'h8354: k.second = 8'hBB;
            16'h8355: begin k.first = 8'hBB; k.second = 8'hDE; end
            16'h8356: k.second = 8'hBC;
            16'h8357: begin k.first = 8'hBC; k.second = 8'hDE; end
            16'h8358: k.second = 8'hBD;
            16'h8359: begin k.first = 8'hBD; k.second = 8'hDE; end
            16'h835A: k.second = 8'hBE;
            16'h835B: begin k.first = 8'hBE; k.second = 8'hDE; end
            16'h835C: k.second = 8'hBF;
            16'h835D: begin k.first = 8'hBF; k.second = 8'hDE; end
            16'h835E: k.second = 8'hC0;
            16'h835F: begin k.first = 8'hC0; k.second = 8'hDE; end
            16'h8360: k.second = 8'hC1;
            16'h8361: begin k.first = 8'hC1; k.second = 8'hDE; end
            16'h8362: k.second = 8'hAF;  16'h8363: k.second = 8'hC2;
            16'h8364: begin k.first = 8'hC2; k.second = 8'hDE; end
            16'h8365: k.second = 8'hC3;
            16'h8366: begin k.first = 8'hC3; k.second = 8'hDE; end
            16'h8367: k.second = 8'hC4;
            16'h8368: begin k.first = 8'hC4; k.second = 8'hDE; end
            16'h8369: k.second = 8'hC5;  16'h836A: k.second = 8'hC6;
            16'h836B: k.second = 8'hC7;  16'h836C: k.second = 8'hC8;
            16'h836D: k.second = 8'hC9;  16'h836E: k.second = 8'hCA;
            16'h836F: begin k.first = 8'hCA; k.second = 8'hDE; end
            16'h8370: begin k.first = 8'hCA; k.second = 8'hDF; end
            16'h8371: k.second = 8'hCB;
            16'h8372: begin k.first = 8'hCB; k.second = 8'hDE; end
            16'h8373: begin k.first = 8'hCB; k.second = 8'hDF; end
            16'h8374: k.second = 8'hCC;
            16'h8375: begin k.first = 8'hCC; k.second = 8'hDE; end
            16'h8376: begin k.first = 8'hCC; k.second = 8'hDF; end
            16'h8377: k.second = 8'hCD;
            16'h8378: begin k.first = 8'hCD; k.second = 8'hDE; end
            16'h8379: begin k.first = 8'hCD; k.second = 8'hDF; end
            16'h837A: k.second = 8'hCE;
            16'h837B: begin k.first = 8'hCE; k.second = 8'hDE; end
            16'h837C: begin k.first = 8'hCE; k.second = 8'hDF; end
            16'h837D: k.second = 8'hCF;  16'h837E: k.second = 8'hD0;
            16'h8380: k.second = 8'hD1;  16'h8381: k.second = 8'hD2;
            16'h8382: k.second = 8'hD3;  16'h8383: k.second = 8'hAC;
            16'h8384: k.second = 8'hD4;  16'h8385: k.second = 8'hAD;
            16'h8386: k.second = 8'hD5;  16'h8387: k.second = 8'hAE;
            16'h8388: k.second = 8'hD6;  16'h8389: k.second = 8'hD7;
            16'h838A: k.second = 8'hD8;  16'h838B: k.second = 8'hD9;
            16'h838C: k.second = 8'hDA;  16'h838D: k.second = 8'hDB;
            16'h838F: k.second = 8'hDC;  16'h8392: k.second = 8'hA6;
            16'h8393: k.second = 8'hDD;
            16'h8394: begin k.first = 8'hB3; k.second = 8'hDE; end
            16'h8140: k.second = 8'h20;
            default: k.hit = 1'b0;
        endcase
        return k;
    endfunction

endpackage

@@ src/cwr_front.sv @@
// Front end: accepts input words, tracks record state and builds result commands.
module cwr_front #(
    parameter int MAX_FIELDS      = cwr_pkg::MAX_FIELDS_DEF,
    parameter int MAX_FIELD_BYTES = cwr_pkg::MAX_FIELD_BYTES_DEF,
    parameter int KANA_FIELD      = cwr_pkg::KANA_FIELD_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  logic [7:0]    data_byte,
    input  logic          q_ready,
    output logic          q_push,
    output cwr_pkg::cmd_t q_cmd
);

    localparam int FI_W = $clog2(MAX_FIELDS);
    localparam int FL_W = $clog2(MAX_FIELD_BYTES);
    localparam logic [FI_W-1:0] FI_TOP = FI_W'(MAX_FIELDS - 1);
    localparam logic [FL_W-1:0] FL_TOP = FL_W'(MAX_FIELD_BYTES - 1);

    logic            mode_reg;
    logic            in_record_reg, in_record_next;
    logic [FI_W-1:0] field_index_reg, field_index_next;
    logic [FL_W-1:0] field_length_reg, field_length_next;
    logic [1:0]      kind_match_reg, kind_match_next;
    logic            name_record_reg, name_record_next;
    logic [7:0]      lead_byte_reg, lead_byte_next;
    logic            lead_pending_reg, lead_pending_next;
    logic            halted_reg, halted_next;
    logic            failed_reg, failed_next;

    logic            accept;
    logic            any;
    cwr_pkg::cmd_t   cmd;
    cwr_pkg::kana_t  kana;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign kana     = cwr_pkg::kana_lookup({lead_byte_reg, data_byte});

    always_comb
    begin
        in_record_next    = in_record_reg;
        field_index_next  = field_index_reg;
        field_length_next = field_length_reg;
        kind_match_next   = kind_match_reg;
        name_record_next  = name_record_reg;
        lead_byte_next    = lead_byte_reg;
        lead_pending_next = lead_pending_reg;
        halted_next       = halted_reg;
        failed_next       = failed_reg;
        cmd               = '0;
        any               = 1'b0;

        if (op == cwr_pkg::OP_END)
        begin
            any = 1'b1;
            if (mode_reg == cwr_pkg::MODE_CSV && in_record_reg && !failed_reg)
            begin
                cmd.r0  = '{data: cwr_pkg::CH_CR, valid: 1'b1, err: 1'b0, last: 1'b0};
                cmd.r1  = '{data: cwr_pkg::CH_LF, valid: 1'b1, err: 1'b0, last: 1'b1};
                cmd.two = 1'b1;
            end
            else
            begin
                cmd.r0 = '{data: 8'h00, valid: 1'b0, err: failed_reg, last: 1'b1};
            end
            in_record_next    = 1'b0;
            field_index_next  = '0;
            field_length_next = '0;
            kind_match_next   = cwr_pkg::KIND_EMPTY;
            name_record_next  = 1'b0;
            lead_byte_next    = '0;
            lead_pending_next = 1'b0;
            halted_next       = 1'b0;
            failed_next       = 1'b0;
        end
        else if (halted_reg || failed_reg)
        begin
            any = 1'b0;
        end
        else if (data_byte == cwr_pkg::CH_NUL)
        begin
            halted_next = 1'b1;
        end
        else if (mode_reg == cwr_pkg::MODE_LF)
        begin
            any = 1'b1;
            if (data_byte == cwr_pkg::CH_LF)
            begin
                cmd.r0  = '{data: cwr_pkg::CH_CR, valid: 1'b1, err: 1'b0, last: 1'b0};
                cmd.r1  = '{data: cwr_pkg::CH_LF, valid: 1'b1, err: 1'b0, last: 1'b0};
                cmd.two = 1'b1;
            end
            else
            begin
                cmd.r0 = '{data: data_byte, valid: 1'b1, err: 1'b0, last: 1'b0};
            end
        end
        else if (data_byte == cwr_pkg::CH_CR || data_byte == cwr_pkg::CH_LF)
        begin
            if (in_record_reg)
            begin
                any     = 1'b1;
                cmd.r0  = '{data: cwr_pkg::CH_CR, valid: 1'b1, err: 1'b0, last: 1'b0};
                cmd.r1  = '{data: cwr_pkg::CH_LF, valid: 1'b1, err: 1'b0, last: 1'b0};
                cmd.two = 1'b1;
                in_record_next    = 1'b0;
                field_index_next  = '0;
                field_length_next = '0;
                kind_match_next   = cwr_pkg::KIND_EMPTY;
                name_record_next  = 1'b0;
                lead_byte_next    = '0;
                lead_pending_next = 1'b0;
            end
        end
        else if (data_byte == cwr_pkg::CH_COMMA)
        begin
            in_record_next = 1'b1;
            any            = 1'b1;
            if (field_index_reg == FI_TOP)
            begin
                failed_next = 1'b1;
                cmd.r0 = '{data: 8'h00, valid: 1'b0, err: 1'b1, last: 1'b0};
            end
            else
            begin
                if (field_index_reg == '0)
                    name_record_next = (kind_match_reg == cwr_pkg::KIND_MATCH);
                field_index_next  = field_index_reg + 1'b1;
                field_length_next = '0;
                lead_pending_next = 1'b0;
                cmd.r0 = '{data: data_byte, valid: 1'b1, err: 1'b0, last: 1'b0};
            end
        end
        else
        begin
            in_record_next = 1'b1;
            if (field_length_reg == FL_TOP)
            begin
                any         = 1'b1;
                failed_next = 1'b1;
                cmd.r0 = '{data: 8'h00, valid: 1'b0, err: 1'b1, last: 1'b0};
            end
            else
            begin
                field_length_next = field_length_reg + 1'b1;
                if (field_index_reg == '0)
                begin
                    if (data_byte == cwr_pkg::CH_ONE && !kind_match_reg[1])
                        kind_match_next = kind_match_reg + 2'd1;
                    else
                        kind_match_next = cwr_pkg::KIND_NONE;
                end
                if (name_record_reg && 32'(field_index_reg) == KANA_FIELD)
                begin
                    // Rewrite the kana field
                    if (lead_pending_reg)
                    begin
                        lead_pending_next = 1'b0;
                        if (kana.hit)
                        begin
                            any = 1'b1;
                            if (kana.first != 8'h00)
                            begin
                                cmd.r0  = '{data: kana.first, valid: 1'b1, err: 1'b0,
                                            last: 1'b0};
                                cmd.r1  = '{data: kana.second, valid: 1'b1, err: 1'b0,
                                            last: 1'b0};
                                cmd.two = 1'b1;
                            end
                            else
                            begin
                                cmd.r0 = '{data: kana.second, valid: 1'b1, err: 1'b0,
                                           last: 1'b0};
                            end
                        end
                    end
                    else if (data_byte >= cwr_pkg::KANA_LO && data_byte <= cwr_pkg::KANA_HI)
                    begin
                        any    = 1'b1;
                        cmd.r0 = '{data: data_byte, valid: 1'b1, err: 1'b0, last: 1'b0};
                    end
                    else if (data_byte <= cwr_pkg::ASCII_HI)
                    begin
                        if (data_byte == cwr_pkg::CH_SPACE)
                        begin
                            any    = 1'b1;
                            cmd.r0 = '{data: data_byte, valid: 1'b1, err: 1'b0, last: 1'b0};
                        end
                    end
                    else
                    begin
                        lead_byte_next    = data_byte;
                        lead_pending_next = 1'b1;
                    end
                end
                else
                begin
                    any    = 1'b1;
                    cmd.r0 = '{data: data_byte, valid: 1'b1, err: 1'b0, last: 1'b0};
                end
            end
        end
    end

    assign q_push = accept && any;
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= cwr_pkg::MODE_CSV;
            in_record_reg    <= 1'b0;
            field_index_reg  <= '0;
            field_length_reg <= '0;
            kind_match_reg   <= cwr_pkg::KIND_EMPTY;
            name_record_reg  <= 1'b0;
            lead_byte_reg    <= '0;
            lead_pending_reg <= 1'b0;
            halted_reg       <= 1'b0;
            failed_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (accept)
            begin
                in_record_reg    <= in_record_next;
                field_index_reg  <= field_index_next;
                field_length_reg <= field_length_next;
                kind_match_reg   <= kind_match_next;
                name_record_reg  <= name_record_next;
                lead_byte_reg    <= lead_byte_next;
                lead_pending_reg <= lead_pending_next;
                halted_reg       <= halted_next;
                failed_reg       <= failed_next;
            end
        end
    end

endmodule

@@ src/cwr_queue.sv @@
// Two-entry command queue between the front and back ends.
module cwr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cwr_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output cwr_pkg::cmd_t pop_cmd
);

    cwr_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && push_ready)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && pop_valid)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push && push_ready, pop && pop_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ src/cwr_back.sv @@
// Back end: serializes queued commands into output words through an output register.
module cwr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cwr_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          error,
    output logic          last
);

    logic          out_valid_reg;
    cwr_pkg::res_t out_reg;
    logic          sec_valid_reg;
    cwr_pkg::res_t sec_reg;
    logic          load;

    assign load  = !out_valid_reg || out_ready;
    assign q_pop = load && !sec_valid_reg && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (sec_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                sec_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= q_valid;
                sec_valid_reg <= q_valid && q_cmd.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sec_valid_reg)
                out_reg <= sec_reg;
            else
            begin
                out_reg <= q_cmd.r0;
                sec_reg <= q_cmd.r1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_reg.data;
    assign byte_valid = out_reg.valid;
    assign error      = out_reg.err;
    assign last       = out_reg.last;

endmodule

@@ src/csv_kana_width_rewriter.sv @@
// Top level of the CSV kana width rewriter: front end, command queue, back end.
// An accepted word's command is queued at the accepting edge and loaded into the output
// register once the back end is free; a stalled output or a pending second word holds it.
// Throughput: one output word per cycle while out_ready is high, set by the byte-wide
// output register in the back end; an input word that yields two words sends them in turn.
// The two-entry queue keeps input flowing while the output stalls, until the queue is full.
// Reset (rst_n low, asynchronous) clears stream state, the queue and sets mode 0.
module csv_kana_width_rewriter #(
    parameter int MAX_FIELDS      = cwr_pkg::MAX_FIELDS_DEF,
    parameter int MAX_FIELD_BYTES = cwr_pkg::MAX_FIELD_BYTES_DEF,
    parameter int KANA_FIELD      = cwr_pkg::KANA_FIELD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       error,
    output logic       last
);

    // Commands from front to queue
    logic          f_push;
    cwr_pkg::cmd_t f_cmd;
    logic          q_push_ready;

    // Commands from queue to back
    logic          q_valid;
    cwr_pkg::cmd_t q_cmd;
    logic          b_pop;

    // Classify each word and build its result words, if any (one or two)
    cwr_front #(
        .MAX_FIELDS      (MAX_FIELDS),
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .KANA_FIELD      (KANA_FIELD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .q_ready   (q_push_ready),
        .q_push    (f_push),
        .q_cmd     (f_cmd)
    );

    // Decouple front and back so each can stall on its own
    cwr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_cmd   (f_cmd),
        .push_ready (q_push_ready),
        .pop        (b_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd)
    );

    // Drain commands one output word at a time
    cwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (b_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .error      (error),
        .last       (last)
    );

endmodule
